// File: rtl/uvs_pkg.sv
// uvs_pkg: shared codes and field widths of the unique value stack
`timescale 1ns / 1ps

package uvs_pkg;

    // default number of stored entries
    localparam int UVS_DEPTH_DEF = 64;

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int S_DATA_W = 2 * VAL_W;
    localparam int M_DATA_W = 16;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [STAT_W-1:0] stat_t;

endpackage

// File: rtl/uvs_ram.sv
// uvs_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module uvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// File: rtl/unique_value_stack_with_search.sv
// unique_value_stack_with_search: bounded newest-first value store with push, pop, update, find
// The store keeps up to DEPTH signed 32-bit values in a ram with separate read and write
// ports, newest first, and takes one request at a time. Push, update and find scan the
// stored entries from the head one ram read per cycle through a single comparator; the
// scan stops at the first match. Such a request holds s_tready low through the scan and
// through the final step that updates the store and loads the result. Pop, clear and
// unused request codes, and requests to an empty store, skip the scan. The result beat
// sits in an output register: a new request is taken while it waits, and only the final
// step of the next request waits for it to leave. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module unique_value_stack_with_search #(
    parameter int DEPTH = uvs_pkg::UVS_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uvs_pkg::S_DATA_W-1:0]  s_tdata,  // key_value[31:0], replacement[63:32]
    input  logic [uvs_pkg::REQ_W-1:0]     s_tuser,  // req_type[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [uvs_pkg::M_DATA_W-1:0]  m_tdata   // status[2:0], found_position[8:3],
                                                    // entry_count[15:9]
);

    import uvs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    req_t          req_reg, req_next;
    val_t          key_reg, key_next;
    val_t          repl_reg, repl_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [AW-1:0] rd_slot_reg, rd_slot_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          found_reg, found_next;
    logic [AW-1:0] match_slot_reg, match_slot_next;
    logic          m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    val_t          wr_data;
    val_t          rd_data;

    logic          accept;
    logic          out_free;
    logic          hit;
    logic          full;
    stat_t         status;
    logic [CW-1:0] pos_full;
    logic [POS_W-1:0] pos;

    uvs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign hit      = rd_valid_reg && (rd_data == key_reg);
    assign full     = (count_reg == CW'(DEPTH));
    assign pos_full = count_reg - CW'(1) - CW'(match_slot_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        repl_next       = repl_reg;
        scan_next       = scan_reg;
        rd_slot_next    = rd_slot_reg;
        rd_valid_next   = 1'b0;
        found_next      = found_reg;
        match_slot_next = match_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = key_reg;
        status          = ST_OK;
        pos             = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_tuser;
                    key_next   = s_tdata[VAL_W-1:0];
                    repl_next  = s_tdata[2*VAL_W-1:VAL_W];
                    found_next = 1'b0;
                    scan_next  = AW'(count_reg - CW'(1));
                    // only push, update and find scan, and only a non-empty store
                    if ((s_tuser == REQ_PUSH || s_tuser == REQ_UPDATE ||
                         s_tuser == REQ_FIND) && count_reg != '0) begin
                        state_next = S_SEARCH;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                // address scan_reg goes out now, data of rd_slot_reg comes back now
                rd_slot_next = scan_reg;
                scan_next    = scan_reg - AW'(1);
                if (hit || (rd_valid_reg && rd_slot_reg == '0)) begin
                    found_next      = hit;
                    match_slot_next = rd_slot_reg;
                    state_next      = S_FINISH;
                end else begin
                    rd_valid_next = 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    case (req_reg)
                        REQ_PUSH: begin
                            if (found_reg) begin
                                status = ST_DUP;
                            end else if (full) begin
                                status = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_POP: begin
                            if (count_reg == '0) begin
                                status = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_UPDATE: begin
                            wr_addr = match_slot_reg;
                            wr_data = repl_reg;
                            if (found_reg) begin
                                wr_en = 1'b1;
                            end else begin
                                status = ST_NOTFOUND;
                            end
                        end
                        REQ_FIND: begin
                            if (found_reg) begin
                                pos = POS_W'(pos_full);
                            end else begin
                                status = ST_NOTFOUND;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    m_valid_next = 1'b1;
                    m_data_next  = {CNT_W'(count_next), pos, status};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        repl_reg       <= repl_next;
        scan_reg       <= scan_next;
        rd_slot_reg    <= rd_slot_next;
        match_slot_reg <= match_slot_next;
        m_data_reg     <= m_data_next;
    end

    // store never holds more than DEPTH entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // a beat is taken only once per request
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request taken while busy");

    // a waiting result reports the current entry count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[M_DATA_W-1:POS_W+STAT_W] == CNT_W'(count_reg)))
        else $error("result count out of step with store");

    // a nonzero position only comes with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[POS_W+STAT_W-1:STAT_W] != '0) |->
            (m_data_reg[STAT_W-1:0] == ST_OK))
        else $error("position given with error status");

endmodule

// File: tb/tb_unique_value_stack_with_search.sv
// tb_unique_value_stack_with_search: randomized stream test of the unique value stack
`timescale 1ns / 1ps

module tb_unique_value_stack_with_search;
    import uvs_pkg::*;

    localparam int DEPTH       = UVS_DEPTH_DEF;
    localparam int RAND_ITEMS  = 1100;
    localparam int CYCLE_LIMIT = 400000;
    // no idling while this range of requests is sent
    localparam int QUIET_FROM  = 400;
    localparam int QUIET_TO    = 650;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_LEN    = 600;
    localparam int IDLE_PCT    = 35;

    typedef struct packed {
        req_t kind;
        val_t key;
        val_t repl;
    } req_item_t;

    typedef struct packed {
        stat_t            status;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } resp_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // key_value[31:0], replacement[63:32]
    logic [REQ_W-1:0]    s_tuser  = '0;  // req_type[2:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // status[2:0], found_position[8:3], entry_count[15:9]

    unique_value_stack_with_search #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    req_item_t req_q[$];
    resp_t     want_q[$];
    val_t      recent_vals[$];

    // shadow of the stack: slot fill-1 is the head
    val_t        shadow[DEPTH];
    int unsigned fill = 0;

    int cycle_cnt = 0;
    int n_results = 0;
    int n_sent    = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int errs      = 0;
    int n_dup = 0, n_full = 0, n_empty = 0, n_miss = 0, n_hit = 0, n_upd = 0;
    int peak_fill = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    function automatic bit quiet_now();
        return n_sent >= QUIET_FROM && n_sent < QUIET_TO;
    endfunction

    function automatic resp_t stack_apply(req_item_t it);
        resp_t r;
        int    hit;
        r.status = ST_OK;
        r.pos    = '0;
        hit      = -1;
        for (int i = int'(fill) - 1; i >= 0; i--) begin
            if (hit < 0 && shadow[i] == it.key) hit = i;
        end
        case (it.kind)
            REQ_PUSH: begin
                if (hit >= 0) begin
                    r.status = ST_DUP;
                    n_dup++;
                end else if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    shadow[fill] = it.key;
                    fill++;
                end
            end
            REQ_POP: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    fill--;
                end
            end
            REQ_UPDATE: begin
                if (hit >= 0) begin
                    shadow[hit] = it.repl;
                    n_upd++;
                end else begin
                    r.status = ST_NOTFOUND;
                    n_miss++;
                end
            end
            REQ_FIND: begin
                if (hit >= 0) begin
                    r.pos = POS_W'(int'(fill) - 1 - hit);
                    n_hit++;
                end else begin
                    r.status = ST_NOTFOUND;
                    n_miss++;
                end
            end
            REQ_CLEAR: fill = 0;
            default: ;
        endcase
        if (int'(fill) > peak_fill) peak_fill = int'(fill);
        r.count = CNT_W'(fill);
        return r;
    endfunction

    task automatic add_req(req_t kind, val_t key, val_t repl);
        req_item_t it;
        it.kind = kind;
        it.key  = key;
        it.repl = repl;
        req_q.push_back(it);
        if (kind == REQ_PUSH || kind == REQ_UPDATE) begin
            recent_vals.push_back(kind == REQ_PUSH ? key : repl);
            if (recent_vals.size() > 96) recent_vals.delete(0);
        end
    endtask

    // reuse a recently written value with the given percent chance so searches hit
    function automatic val_t pick_val(int pct_known);
        if (recent_vals.size() > 0 && $urandom_range(99) < pct_known)
            return recent_vals[$urandom_range(recent_vals.size() - 1)];
        return $urandom;
    endfunction

    // stimulus
    initial begin
        int made;
        int mode;
        int len;
        int w;

        // directed: empty store, extremes, duplicates, first-match rules, spare codes
        add_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
        add_req(REQ_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        add_req(REQ_UPDATE, 32'h0000_0000, 32'h1111_1111);
        add_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_PUSH,   32'h8000_0000, 32'h0000_0000);
        add_req(REQ_PUSH,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_PUSH,   32'h0000_0000, 32'h8000_0000);
        add_req(REQ_PUSH,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_req(REQ_PUSH,   32'h7FFF_FFFF, 32'h0000_0000);
        add_req(REQ_FIND,   32'h8000_0000, 32'h0000_0000);
        add_req(REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        add_req(REQ_FIND,   32'h0000_1234, 32'h0000_0000);
        // makes a second copy of an existing value
        add_req(REQ_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF);
        add_req(REQ_FIND,   32'h7FFF_FFFF, 32'h0000_0000);
        add_req(REQ_UPDATE, 32'h7FFF_FFFF, 32'h5555_AAAA);
        add_req(REQ_FIND,   32'h7FFF_FFFF, 32'h0000_0000);
        add_req(REQ_UPDATE, 32'h1234_5678, 32'hAAAA_5555);
        add_req(req_t'(REQ_CLEAR + 3'd1), $urandom, $urandom);
        add_req(req_t'(REQ_CLEAR + 3'd2), $urandom, $urandom);
        add_req(req_t'(REQ_CLEAR + 3'd3), $urandom, $urandom);
        add_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
        add_req(REQ_PUSH,   32'hFFFF_FFFF, 32'h0000_0000);
        add_req(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);
        add_req(REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000);

        made = 0;
        while (made < RAND_ITEMS) begin
            mode = $urandom_range(99);
            if (mode < 20) begin
                // fill run: usually reaches full and keeps pushing
                len = $urandom_range(40, 75);
                repeat (len) add_req(REQ_PUSH, pick_val(8), $urandom);
                repeat (8) add_req(REQ_FIND, pick_val(85), $urandom);
                made += len + 8;
            end else if (mode < 30) begin
                len = $urandom_range(10, 70);
                repeat (len) add_req(REQ_POP, $urandom, $urandom);
                made += len;
            end else begin
                repeat (40) begin
                    w = $urandom_range(99);
                    if (w < 32)      add_req(REQ_PUSH, pick_val(40), $urandom);
                    else if (w < 52) add_req(REQ_POP, $urandom, $urandom);
                    else if (w < 68) add_req(REQ_UPDATE, pick_val(80), pick_val(20));
                    else if (w < 91) add_req(REQ_FIND, pick_val(75), $urandom);
                    else if (w < 94) add_req(REQ_CLEAR, $urandom, $urandom);
                    else             add_req(req_t'(REQ_CLEAR + $urandom_range(1, 3)),
                                             $urandom, $urandom);
                    if (w < 94) made++;
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        wait (req_q.size() == 0 && !s_tvalid);
        wait (want_q.size() == 0);
        repeat (DEPTH + 8) @(posedge aclk);
        if (want_q.size() != 0) begin
            errs++;
            $display("error: %0d results never arrived", want_q.size());
        end
        $display("ran %0d requests, checked %0d results, peak depth %0d of %0d",
                 n_sent, n_results, peak_fill, DEPTH);
        $display("duplicates %0d, full %0d, empty pops %0d, misses %0d, find hits %0d, %s",
                 n_dup, n_full, n_empty, n_miss, n_hit,
                 $sformatf("updates %0d, errors %0d", n_upd, errs));
        if (errs == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d requests left", cycle_cnt, req_q.size());
        $display("status: fail");
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        resp_t exp_r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_r = stack_apply(req_q[0]);
                want_q.push_back(exp_r);
                req_q.delete(0);
                n_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (req_q.size() > 0 && (quiet_now() || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {req_q[0].repl, req_q[0].key};
                    s_tuser  <= req_q[0].kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the output register fills and the input stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && n_results == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        resp_t got;
        resp_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(resp_t)-1:0];
                got.status = m_tdata[STAT_W-1:0];
                got.pos    = m_tdata[STAT_W +: POS_W];
                got.count  = m_tdata[STAT_W+POS_W +: CNT_W];
                n_results <= n_results + 1;
                if (want_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("error: unexpected result beat status %0d pos %0d count %0d",
                                 got.status, got.pos, got.count);
                end else begin
                    exp_r = want_q.pop_front();
                    if (got.status !== exp_r.status || got.pos !== exp_r.pos
                            || got.count !== exp_r.count) begin
                        errs++;
                        if (errs <= 10)
                            $display("error: beat %0d expected status %0d pos %0d count %0d, %s",
                                     n_results, exp_r.status, exp_r.pos, exp_r.count,
                                     $sformatf("got status %0d pos %0d count %0d",
                                               got.status, got.pos, got.count));
                    end
                end
            end
            m_tready <= (hold_left == 0)
                        && (quiet_now() || $urandom_range(99) >= IDLE_PCT);
        end
    end

endmodule

// File: unique_value_stack_with_search.f
rtl/uvs_pkg.sv
rtl/uvs_ram.sv
rtl/unique_value_stack_with_search.sv
tb/tb_unique_value_stack_with_search.sv
